// ===== rtl/mfi_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the sigmoid table for the perceptron inference block.
// No dependencies; every file but mfi_ram imports it.
package mfi_pkg;

   localparam int DATA_W          = 16;
   localparam int WADDR_W         = 11;
   localparam int WEIGHT_DEPTH    = 2048;
   localparam int INPUT_MAX_DEF   = 16;
   localparam int HIDDEN_MAX_DEF  = 16;
   localparam int LAYER_MAX_DEF   = 4;
   localparam int CFG_IDX_W       = 3;
   localparam int CFG_DATA_W      = 13;
   localparam int REQ_TDATA_W     = 32;
   localparam int RSP_TDATA_W     = 16;
   localparam int ONE_Q           = 4096;

   typedef enum logic [1:0] {
      ACT_SIGMOID = 2'd0,
      ACT_CLAMP   = 2'd1,
      ACT_LEAKY   = 2'd2,
      ACT_PASS    = 2'd3
   } act_sel_type;

   typedef enum logic {
      KIND_WEIGHT  = 1'b0,
      KIND_FEATURE = 1'b1
   } item_kind_type;

   typedef struct packed {
      item_kind_type              kind;
      logic [WADDR_W-1:0]         addr;
      logic [DATA_W-1:0]          value;
      logic                       last;
   } item_type;

   typedef struct packed {
      logic [4:0]  input_count;
      logic [4:0]  hidden_count;
      logic [2:0]  hidden_layers;
      act_sel_type hidden_act;
      act_sel_type output_act;
      logic [12:0] leak;
   } cfg_type;

   // sigmoid at steps of 0.5 from 0 to 8, unsigned Q0.12
   function automatic logic [11:0] sig_rom(input logic [4:0] idx);
      logic [11:0] y;
      unique case (idx)
         5'd0:    y = 12'd2048;
         5'd1:    y = 12'd2550;
         5'd2:    y = 12'd2994;
         5'd3:    y = 12'd3349;
         5'd4:    y = 12'd3608;
         5'd5:    y = 12'd3785;
         5'd6:    y = 12'd3902;
         5'd7:    y = 12'd3976;
         5'd8:    y = 12'd4022;
         5'd9:    y = 12'd4051;
         5'd10:   y = 12'd4069;
         5'd11:   y = 12'd4079;
         5'd12:   y = 12'd4086;
         5'd13:   y = 12'd4090;
         5'd14:   y = 12'd4092;
         5'd15:   y = 12'd4094;
         5'd16:   y = 12'd4095;
         default: y = 12'd0;
      endcase
      return y;
   endfunction

endpackage

// ===== rtl/mfi_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfi_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mfi_front.sv =====
`timescale 1ns / 1ps
// Request intake: decodes the request stream into items and holds them in a
// two-entry queue for the engine. Depends on mfi_pkg.
module mfi_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mfi_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic                                req_tlast,
   input  logic                                req_tuser,
   output logic                                item_valid,
   output mfi_pkg::item_type                   item,
   input  logic                                item_pop
);
   import mfi_pkg::*;

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   dec;

   always_comb begin
      dec.kind  = item_kind_type'(req_tuser);
      dec.addr  = req_tdata[WADDR_W-1:0];
      dec.value = req_tdata[WADDR_W+DATA_W-1:WADDR_W];
      dec.last  = req_tlast;
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign item_valid = (count_ff != 2'd0);
   assign item       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = item_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, item_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

// ===== rtl/mfi_act.sv =====
`timescale 1ns / 1ps
// Two-stage activation unit: sigmoid by table and interpolation, clamp to
// plus or minus one, leaky relu or pass-through. Depends on mfi_pkg.
module mfi_act #(
   parameter int TAG_W = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic signed [mfi_pkg::DATA_W-1:0] in_u,
   input  mfi_pkg::act_sel_type             in_sel,
   input  logic [12:0]                      leak,
   input  logic [TAG_W-1:0]                 in_tag,
   output logic                             out_valid,
   output logic signed [mfi_pkg::DATA_W-1:0] out_y,
   output logic [TAG_W-1:0]                 out_tag,
   output logic                             busy
);
   import mfi_pkg::*;

   localparam logic signed [29:0] LR_MAX = 30'(2**(DATA_W-1) - 1);
   localparam logic signed [29:0] LR_MIN = 30'(-(2**(DATA_W-1)));

   // stage A
   logic                     a_v_ff, a_v_in;
   act_sel_type              a_sel_ff;
   logic signed [DATA_W-1:0] a_u_ff;
   logic                     a_neg_ff;
   logic                     a_hi_ff;
   logic [11:0]              a_base_ff;
   logic [22:0]              a_interp_ff;
   logic signed [29:0]       a_lp_ff;
   logic [TAG_W-1:0]         a_tag_ff;

   logic [16:0]              mag;
   logic [5:0]               idx;
   logic [10:0]              frac;
   logic [11:0]              base, nxt, diff;
   logic signed [29:0]       lp;

   // stage B
   logic                     b_v_ff, b_v_in;
   logic signed [DATA_W-1:0] b_y_ff, b_y_in;
   logic [TAG_W-1:0]         b_tag_ff;

   logic [11:0]              sig_mag;
   logic [12:0]              sig_y;
   logic [22:0]              interp_r;
   logic signed [29:0]       lr;

   function automatic logic [11:0] base_add(input logic [11:0] b, input logic [11:0] d);
      return b + d;
   endfunction

   always_comb begin
      mag  = in_u[DATA_W-1] ? 17'(-$signed({in_u[DATA_W-1], in_u})) : {1'b0, in_u};
      idx  = mag[16:11];
      frac = mag[10:0];
      base = sig_rom(idx[4:0]);
      nxt  = sig_rom(idx[4:0] + 5'd1);
      diff = nxt - base;
      lp   = in_u * $signed({1'b0, leak});
   end

   assign a_v_in = in_valid;

   always_comb begin
      interp_r = (a_interp_ff + 23'd1024) >> 11;
      sig_mag  = a_hi_ff ? 12'd4095 : base_add(a_base_ff, interp_r[11:0]);
      sig_y    = a_neg_ff ? (13'(ONE_Q) - {1'b0, sig_mag}) : {1'b0, sig_mag};
      lr       = (a_lp_ff + 30'sd2048) >>> 12;
      unique case (a_sel_ff)
         ACT_SIGMOID: b_y_in = DATA_W'(sig_y);
         ACT_CLAMP: begin
            if (a_u_ff < -DATA_W'(ONE_Q)) begin
               b_y_in = -DATA_W'(ONE_Q);
            end else if (a_u_ff > DATA_W'(ONE_Q)) begin
               b_y_in = DATA_W'(ONE_Q);
            end else begin
               b_y_in = a_u_ff;
            end
         end
         ACT_LEAKY: begin
            if (!a_u_ff[DATA_W-1]) begin
               b_y_in = a_u_ff;
            end else if (lr > LR_MAX) begin
               b_y_in = LR_MAX[DATA_W-1:0];
            end else if (lr < LR_MIN) begin
               b_y_in = LR_MIN[DATA_W-1:0];
            end else begin
               b_y_in = lr[DATA_W-1:0];
            end
         end
         ACT_PASS: b_y_in = a_u_ff;
         default:  b_y_in = a_u_ff;
      endcase
   end

   assign b_v_in = a_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else begin
         a_v_ff <= a_v_in;
         b_v_ff <= b_v_in;
      end
   end

   always_ff @(posedge clock) begin
      a_sel_ff    <= in_sel;
      a_u_ff      <= in_u;
      a_neg_ff    <= in_u[DATA_W-1];
      a_hi_ff     <= (idx >= 6'd16);
      a_base_ff   <= base;
      a_interp_ff <= diff * frac;
      a_lp_ff     <= lp;
      a_tag_ff    <= in_tag;
      b_y_ff      <= b_y_in;
      b_tag_ff    <= a_tag_ff;
   end

   assign out_valid = b_v_ff;
   assign out_y     = b_y_ff;
   assign out_tag   = b_tag_ff;
   assign busy      = a_v_ff || b_v_ff;

endmodule

// ===== rtl/mfi_engine.sv =====
`timescale 1ns / 1ps
// Back end: stores weights and features, sequences the layers over one
// pipelined multiply-accumulate unit. Depends on mfi_pkg, mfi_ram, mfi_act.
module mfi_engine #(
   parameter int INPUT_MAX  = mfi_pkg::INPUT_MAX_DEF,
   parameter int HIDDEN_MAX = mfi_pkg::HIDDEN_MAX_DEF,
   parameter int LAYER_MAX  = mfi_pkg::LAYER_MAX_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  mfi_pkg::cfg_type                 cfg,
   input  logic                             item_valid,
   input  mfi_pkg::item_type                item,
   output logic                             item_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [mfi_pkg::DATA_W-1:0]       rsp_pred,
   output logic                             rsp_sat
);
   import mfi_pkg::*;

   localparam int KMAX   = (INPUT_MAX > HIDDEN_MAX) ? INPUT_MAX : HIDDEN_MAX;
   localparam int KW     = $clog2(KMAX + 1);
   localparam int FAW    = (INPUT_MAX > 1) ? $clog2(INPUT_MAX) : 1;
   localparam int HAW    = (HIDDEN_MAX > 1) ? $clog2(HIDDEN_MAX) : 1;
   localparam int FCW    = $clog2(INPUT_MAX + 1);
   localparam int LW     = $clog2(LAYER_MAX + 1);
   localparam int PROD_W = 2 * DATA_W;
   localparam int ACC_W  = PROD_W + KW + 2;
   localparam int LWW    = (2 * KW > WADDR_W) ? 2 * KW : WADDR_W;

   localparam logic signed [ACC_W-1:0] SUM_MAX = ACC_W'(2**(DATA_W-1) - 1);
   localparam logic signed [ACC_W-1:0] SUM_MIN = ACC_W'(-(2**(DATA_W-1)));

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SETUP = 4'b0010,
      ST_ISSUE = 4'b0100,
      ST_DRAIN = 4'b1000
   } eng_state_type;

   eng_state_type      state_ff, state_in;
   logic [FCW-1:0]     fcnt_ff, fcnt_in;
   logic [LW-1:0]      l_ff, l_in;
   logic [KW-1:0]      k_ff, k_in;
   logic [HAW-1:0]     n_ff, n_in;
   logic [WADDR_W-1:0] wptr_ff, wptr_in;
   logic [WADDR_W-1:0] bptr_ff, bptr_in;
   logic               sat_ff, sat_in;
   logic               rsp_v_ff, rsp_v_in;
   logic [DATA_W-1:0]  rsp_pred_ff;
   logic               rsp_sat_ff;

   logic [KW-1:0]      ni, nh, nin, nout;
   logic [LW-1:0]      nl;
   logic [LWW-1:0]     nin_w, nout_w, lay_words;
   logic               is_out, iss_v, iss_bias, busy, start;

   // RAM hookups
   logic               w_we, f_we, a_we;
   logic [WADDR_W-1:0] w_raddr;
   logic [DATA_W-1:0]  w_rd, f_rd, a_rd;
   logic [FAW-1:0]     f_waddr;
   logic [HAW:0]       a_waddr, a_raddr;

   // pipeline
   logic               s1_v_ff, s1_bias_ff, s1_feat_ff;
   logic [HAW-1:0]     s1_n_ff;
   logic               s2_v_ff, s2_bias_ff;
   logic [HAW-1:0]     s2_n_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in, bq;
   logic signed [DATA_W-1:0] xop, wop;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, prod_x, sum_ff, sum_in, t, r;
   logic               s3_v_ff;
   logic [HAW-1:0]     s3_n_ff;
   logic               s4_v_ff;
   logic [HAW-1:0]     s4_n_ff;
   logic signed [DATA_W-1:0] u_ff, u_in;
   logic               sat_now;
   act_sel_type        sel;
   logic               act_v, act_busy;
   logic signed [DATA_W-1:0] act_y;
   logic [HAW-1:0]     act_n;

   // effective counts
   always_comb begin
      if (cfg.input_count == 5'd0) begin
         ni = KW'(1);
      end else if (int'(cfg.input_count) > INPUT_MAX) begin
         ni = KW'(INPUT_MAX);
      end else begin
         ni = KW'(cfg.input_count);
      end
      if (cfg.hidden_count == 5'd0) begin
         nh = KW'(1);
      end else if (int'(cfg.hidden_count) > HIDDEN_MAX) begin
         nh = KW'(HIDDEN_MAX);
      end else begin
         nh = KW'(cfg.hidden_count);
      end
      if (cfg.hidden_layers == 3'd0) begin
         nl = LW'(1);
      end else if (int'(cfg.hidden_layers) > LAYER_MAX) begin
         nl = LW'(LAYER_MAX);
      end else begin
         nl = LW'(cfg.hidden_layers);
      end
      is_out    = (l_ff == nl);
      nin       = (l_ff == '0) ? ni : nh;
      nout      = is_out ? KW'(1) : nh;
      nin_w     = LWW'(nin);
      nout_w    = LWW'(nout);
      lay_words = nin_w * nout_w;
   end

   // issue side
   assign iss_v    = (state_ff == ST_ISSUE);
   assign iss_bias = (k_ff == nin);
   assign w_raddr  = iss_bias ? bptr_ff : wptr_ff;
   assign a_raddr  = {~l_ff[0], k_ff[HAW-1:0]};
   assign busy     = s1_v_ff || s2_v_ff || s3_v_ff || s4_v_ff || act_busy;

   // request intake
   always_comb begin
      item_pop = 1'b0;
      if (state_ff == ST_IDLE && item_valid) begin
         item_pop = !(item.kind == KIND_FEATURE && item.last && rsp_v_ff);
      end
      w_we    = item_pop && (item.kind == KIND_WEIGHT);
      f_we    = item_pop && (item.kind == KIND_FEATURE) && (fcnt_ff < FCW'(INPUT_MAX));
      f_waddr = fcnt_ff[FAW-1:0];
      start   = item_pop && (item.kind == KIND_FEATURE) && item.last;
   end

   always_comb begin
      state_in = state_ff;
      fcnt_in  = fcnt_ff;
      l_in     = l_ff;
      k_in     = k_ff;
      n_in     = n_ff;
      wptr_in  = wptr_ff;
      bptr_in  = bptr_ff;
      sat_in   = sat_ff | (s4_v_ff ? 1'b0 : 1'b0);
      if (f_we) begin
         fcnt_in = fcnt_ff + FCW'(1);
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               fcnt_in  = '0;
               l_in     = '0;
               wptr_in  = '0;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            bptr_in  = wptr_ff + lay_words[WADDR_W-1:0];
            k_in     = '0;
            n_in     = '0;
            state_in = ST_ISSUE;
         end
         ST_ISSUE: begin
            if (!iss_bias) begin
               k_in    = k_ff + KW'(1);
               wptr_in = wptr_ff + WADDR_W'(1);
            end else begin
               k_in    = '0;
               bptr_in = bptr_ff + WADDR_W'(1);
               n_in    = n_ff + HAW'(1);
               if (KW'(n_ff) == nout - KW'(1)) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            // wait for the last neuron of the layer to be written back
            if (!busy) begin
               if (is_out) begin
                  state_in = ST_IDLE;
               end else begin
                  l_in     = l_ff + LW'(1);
                  wptr_in  = bptr_ff;
                  state_in = ST_SETUP;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // multiply, accumulate, round and saturate
   always_comb begin
      xop     = s1_feat_ff ? $signed(f_rd) : $signed(a_rd);
      wop     = $signed(w_rd);
      bq      = {{(PROD_W-DATA_W-12){w_rd[DATA_W-1]}}, w_rd, 12'b0};
      prod_in = s1_bias_ff ? -bq : xop * wop;
      prod_x  = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      sum_in  = acc_ff + prod_x;
      acc_in  = acc_ff;
      if (s2_v_ff) begin
         acc_in = s2_bias_ff ? '0 : sum_in;
      end
      t       = sum_ff + ACC_W'(2048);
      r       = t >>> 12;
      sat_now = 1'b0;
      if (r > SUM_MAX) begin
         u_in    = SUM_MAX[DATA_W-1:0];
         sat_now = 1'b1;
      end else if (r < SUM_MIN) begin
         u_in    = SUM_MIN[DATA_W-1:0];
         sat_now = 1'b1;
      end else begin
         u_in = r[DATA_W-1:0];
      end
      sel = is_out ? cfg.output_act : cfg.hidden_act;
   end

   // write back: hidden outputs to the layer RAM, the last one to the response
   always_comb begin
      a_we     = act_v && !is_out;
      a_waddr  = {l_ff[0], act_n};
      rsp_v_in = rsp_v_ff;
      if (rsp_v_ff && rsp_ready) begin
         rsp_v_in = 1'b0;
      end
      if (act_v && is_out) begin
         rsp_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fcnt_ff  <= '0;
         l_ff     <= '0;
         k_ff     <= '0;
         n_ff     <= '0;
         wptr_ff  <= '0;
         bptr_ff  <= '0;
         sat_ff   <= 1'b0;
         rsp_v_ff <= 1'b0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         acc_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fcnt_ff  <= fcnt_in;
         l_ff     <= l_in;
         k_ff     <= k_in;
         n_ff     <= n_in;
         wptr_ff  <= wptr_in;
         bptr_ff  <= bptr_in;
         // the unrounded sum sits in sum_ff while its stage-3 valid is high
         if (start) begin
            sat_ff <= 1'b0;
         end else if (s3_v_ff && sat_now) begin
            sat_ff <= 1'b1;
         end else begin
            sat_ff <= sat_in;
         end
         rsp_v_ff <= rsp_v_in;
         s1_v_ff  <= iss_v;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff && s2_bias_ff;
         s4_v_ff  <= s3_v_ff;
         acc_ff   <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_bias_ff <= iss_bias;
      s1_feat_ff <= (l_ff == '0);
      s1_n_ff    <= n_ff;
      s2_bias_ff <= s1_bias_ff;
      s2_n_ff    <= s1_n_ff;
      prod_ff    <= prod_in;
      sum_ff     <= sum_in;
      s3_n_ff    <= s2_n_ff;
      u_ff       <= u_in;
      s4_n_ff    <= s3_n_ff;
      if (act_v && is_out) begin
         rsp_pred_ff <= act_y;
         rsp_sat_ff  <= sat_ff;
      end
   end

   mfi_ram #(.WIDTH(DATA_W), .DEPTH(WEIGHT_DEPTH), .AW(WADDR_W)) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (item.addr),
      .wr_data (item.value),
      .rd_addr (w_raddr),
      .rd_data (w_rd)
   );

   mfi_ram #(.WIDTH(DATA_W), .DEPTH(2**FAW), .AW(FAW)) u_feature_ram (
      .clock   (clock),
      .wr_en   (f_we),
      .wr_addr (f_waddr),
      .wr_data (item.value),
      .rd_addr (k_ff[FAW-1:0]),
      .rd_data (f_rd)
   );

   mfi_ram #(.WIDTH(DATA_W), .DEPTH(2**(HAW+1)), .AW(HAW+1)) u_layer_ram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (act_y),
      .rd_addr (a_raddr),
      .rd_data (a_rd)
   );

   mfi_act #(.TAG_W(HAW)) u_act (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_v_ff),
      .in_u      (u_ff),
      .in_sel    (sel),
      .leak      (cfg.leak),
      .in_tag    (s4_n_ff),
      .out_valid (act_v),
      .out_y     (act_y),
      .out_tag   (act_n),
      .busy      (act_busy)
   );

   assign rsp_valid = rsp_v_ff;
   assign rsp_pred  = rsp_pred_ff;
   assign rsp_sat   = rsp_sat_ff;

endmodule

// ===== rtl/mlp_forward_inference.sv =====
`timescale 1ns / 1ps
// Multilayer perceptron inference, Q4.12, one output neuron.
// Channels: req_ carries weight writes (tuser 0) and features (tuser 1);
//   tlast on a feature closes the sample and starts a forward pass.
//   rsp_ returns one response per sample: the prediction and a flag set if
//   any weighted sum saturated. csr_ writes the six configuration registers
//   (ready is always high); write them only while the block is idle.
// Throughput: weight writes and plain features pass one per cycle through
//   a two-entry queue while the engine is idle. A forward pass runs on one
//   pipelined multiply-accumulate unit, one term per cycle: each layer issues
//   outputs*(inputs+1) terms, bias included, between a setup state and a
//   drain of the pipeline.
// Reset clears the control state, the feature count and the configuration
//   (16, 16, 1, sigmoid, sigmoid, leak 41); weights and features are
//   undefined until written. A stalled response holds its data; the next
//   sample's last feature waits in the queue until the response is taken.
// Depends on mfi_pkg, mfi_front, mfi_engine.
module mlp_forward_inference #(
   parameter int INPUT_MAX  = mfi_pkg::INPUT_MAX_DEF,
   parameter int HIDDEN_MAX = mfi_pkg::HIDDEN_MAX_DEF,
   parameter int LAYER_MAX  = mfi_pkg::LAYER_MAX_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mfi_pkg::REQ_TDATA_W-1:0]    req_tdata,  // weight_index[10:0], value[26:11]
   input  logic                               req_tlast,  // last
   input  logic                               req_tuser,  // mode
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [mfi_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // prediction[15:0]
   output logic                               rsp_tuser,  // saturated
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mfi_pkg::CFG_IDX_W-1:0]      csr_index,
   input  logic [mfi_pkg::CFG_DATA_W-1:0]     csr_data
);
   import mfi_pkg::*;

   typedef enum logic [CFG_IDX_W-1:0] {
      REG_INPUT_COUNT  = 3'd0,
      REG_HIDDEN_COUNT = 3'd1,
      REG_HIDDEN_LAYERS = 3'd2,
      REG_HIDDEN_ACT   = 3'd3,
      REG_OUTPUT_ACT   = 3'd4,
      REG_LEAK         = 3'd5
   } reg_index_type;

   cfg_type  cfg_ff, cfg_in;
   logic     item_valid, item_pop;
   item_type item;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_INPUT_COUNT:   cfg_in.input_count   = csr_data[4:0];
            REG_HIDDEN_COUNT:  cfg_in.hidden_count  = csr_data[4:0];
            REG_HIDDEN_LAYERS: cfg_in.hidden_layers = csr_data[2:0];
            REG_HIDDEN_ACT:    cfg_in.hidden_act    = act_sel_type'(csr_data[1:0]);
            REG_OUTPUT_ACT:    cfg_in.output_act    = act_sel_type'(csr_data[1:0]);
            REG_LEAK:          cfg_in.leak          = csr_data[12:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.input_count   <= 5'd16;
         cfg_ff.hidden_count  <= 5'd16;
         cfg_ff.hidden_layers <= 3'd1;
         cfg_ff.hidden_act    <= ACT_SIGMOID;
         cfg_ff.output_act    <= ACT_SIGMOID;
         cfg_ff.leak          <= 13'd41;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mfi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   mfi_engine #(
      .INPUT_MAX  (INPUT_MAX),
      .HIDDEN_MAX (HIDDEN_MAX),
      .LAYER_MAX  (LAYER_MAX)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_pred   (rsp_tdata),
      .rsp_sat    (rsp_tuser)
   );

endmodule

// ===== dv/mlp_forward_inference_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for mlp_forward_inference: weight and feature requests with
// random content, a predictor of the fixed-point forward pass and an in-order check.
// Depends on mfi_pkg and the block's RTL.
module mlp_forward_inference_test;
   import mfi_pkg::*;

   localparam int CSR_INPUT_COUNT  = 0;
   localparam int CSR_HIDDEN_COUNT = 1;
   localparam int CSR_HIDDEN_LAYERS = 2;
   localparam int CSR_HIDDEN_ACT   = 3;
   localparam int CSR_OUTPUT_ACT   = 4;
   localparam int CSR_LEAK         = 5;
   localparam int SETTLE_CYCLES    = 1500;
   localparam longint CYCLE_LIMIT  = 64'd3000000;

   typedef struct {
      logic [15:0] prediction;
      logic        saturated;
   } prediction_type;

   class mlp_scoreboard;
      logic signed [15:0] weights[WEIGHT_DEPTH];
      logic signed [15:0] features[INPUT_MAX_DEF];
      int                 outs[LAYER_MAX_DEF][HIDDEN_MAX_DEF];
      int                 feature_count;
      int                 n_in, n_hid, n_lay;
      act_sel_type        hid_act, out_act;
      int                 leak;
      prediction_type     pending[$];
      int                 errors;

      function void reset_state();
         feature_count = 0;
         n_in = 16; n_hid = 16; n_lay = 1;
         hid_act = ACT_SIGMOID; out_act = ACT_SIGMOID; leak = 41;
         errors = 0;
      endfunction

      function void write_csr(int idx, int val);
         case (idx)
            CSR_INPUT_COUNT:   n_in = val & 31;
            CSR_HIDDEN_COUNT:  n_hid = val & 31;
            CSR_HIDDEN_LAYERS: n_lay = val & 7;
            CSR_HIDDEN_ACT:    hid_act = act_sel_type'(val & 3);
            CSR_OUTPUT_ACT:    out_act = act_sel_type'(val & 3);
            CSR_LEAK:          leak = val & 13'h1fff;
            default: ;
         endcase
      endfunction

      function longint round_q12(longint v);
         longint t;
         t = v + 2048;
         return t >>> 12;
      endfunction

      function int sat16(longint v, ref bit flag);
         if (v > 32767) begin
            flag = 1;
            return 32767;
         end
         if (v < -32768) begin
            flag = 1;
            return -32768;
         end
         return int'(v);
      endfunction

      function int sigmoid(int u);
         int a, idx, frac, y;
         a = u < 0 ? -u : u;
         idx = a >> 11;
         frac = a & 2047;
         if (idx >= 16) y = sig_rom(5'd16);
         else y = sig_rom(5'(idx)) +
                  (((sig_rom(5'(idx + 1)) - sig_rom(5'(idx))) * frac + 1024) >>> 11);
         return u < 0 ? ONE_Q - y : y;
      endfunction

      function int activate(act_sel_type sel, int u);
         bit dummy;
         case (sel)
            ACT_SIGMOID: return sigmoid(u);
            ACT_CLAMP:   return u < -ONE_Q ? -ONE_Q : (u > ONE_Q ? ONE_Q : u);
            ACT_LEAKY: begin
               if (u >= 0) return u;
               return sat16(round_q12(longint'(u) * leak), dummy);
            end
            default:     return u;
         endcase
      endfunction

      function int neuron(longint acc, int bias, ref bit flag);
         return sat16(round_q12(acc - longint'(bias) * ONE_Q), flag);
      endfunction

      function int clampc(int v, int hi);
         return v < 1 ? 1 : (v > hi ? hi : v);
      endfunction

      function prediction_type forward_pass();
         int ni, nh, nl, base, y;
         longint acc;
         bit flag;
         prediction_type r;
         flag = 0;
         ni = clampc(n_in, INPUT_MAX_DEF);
         nh = clampc(n_hid, HIDDEN_MAX_DEF);
         nl = clampc(n_lay, LAYER_MAX_DEF);
         for (int h = 0; h < nh; h++) begin
            acc = 0;
            for (int i = 0; i < ni; i++) acc += longint'(features[i]) * weights[h * ni + i];
            outs[0][h] = activate(hid_act, neuron(acc, weights[nh * ni + h], flag));
         end
         base = nh * ni + nh;
         for (int l = 0; l + 1 < nl; l++) begin
            for (int h2 = 0; h2 < nh; h2++) begin
               acc = 0;
               for (int h1 = 0; h1 < nh; h1++)
                  acc += longint'(outs[l][h1]) * weights[base + h2 * nh + h1];
               outs[l + 1][h2] = activate(hid_act,
                  neuron(acc, weights[base + nh * nh + h2], flag));
            end
            base += nh * nh + nh;
         end
         acc = 0;
         for (int h = 0; h < nh; h++) acc += longint'(outs[nl - 1][h]) * weights[base + h];
         y = activate(out_act, neuron(acc, weights[base + nh], flag));
         r.prediction = y[15:0];
         r.saturated = flag;
         return r;
      endfunction

      function void note_request(item_kind_type kind, int addr, logic [15:0] val, bit last);
         if (kind == KIND_WEIGHT) begin
            weights[addr] = val;
            return;
         end
         if (feature_count < INPUT_MAX_DEF) begin
            features[feature_count] = val;
            feature_count++;
         end
         if (last) begin
            pending.push_back(forward_pass());
            feature_count = 0;
         end
      endfunction

      function void check_response(logic [15:0] pred, logic sat);
         prediction_type e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response pred=%h sat=%b", pred, sat);
            return;
         end
         e = pending.pop_front();
         if (pred !== e.prediction || sat !== e.saturated) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected pred=%h sat=%b, actual pred=%h sat=%b",
                        e.prediction, e.saturated, pred, sat);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tready, req_tlast = 0, req_tuser = 0;
   logic [31:0] req_tdata = '0;
   logic rsp_tvalid, rsp_tready = 0, rsp_tuser;
   logic [15:0] rsp_tdata;
   logic csr_valid = 0, csr_ready;
   logic [2:0] csr_index = '0;
   logic [12:0] csr_data = '0;

   mlp_scoreboard sb = new();
   int send_idle_pct, stall_pct;
   longint cycles;
   int n_in, n_hid, n_lay;

   mlp_forward_inference i_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser);
   end

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   task automatic write_csr(int idx, int val);
      csr_valid <= 1;
      csr_index <= idx[2:0];
      csr_data <= val[12:0];
      do @(posedge clock); while (!csr_ready);
      sb.write_csr(idx, val);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // one request; hold valid until it is taken
   task automatic send(item_kind_type kind, int addr, int val, bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= kind;
      req_tlast <= last;
      req_tdata <= {5'd0, val[15:0], addr[10:0]};
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, addr, val[15:0], last);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic int rand_value();
      case ($urandom_range(5))
         0: return $urandom_range(65535);
         1: return $urandom_range(1) ? 32767 : -32768;
         default: return int'($urandom_range(4096)) - 2048;
      endcase
   endfunction

   function automatic int weight_words(int ni, int nh, int nl);
      return nh * ni + nh + (nl - 1) * (nh * nh + nh) + nh + 1;
   endfunction

   // load every weight in use, then the given number of samples
   task automatic run_samples(int samples, int scale);
      int nw, nf, ni;
      ni = sb.clampc(n_in, INPUT_MAX_DEF);
      nw = weight_words(ni, sb.clampc(n_hid, HIDDEN_MAX_DEF), sb.clampc(n_lay, LAYER_MAX_DEF));
      for (int a = 0; a < nw; a++)
         send(KIND_WEIGHT, a, scale ? rand_value() : int'($urandom_range(1023)) - 512, 0);
      for (int s = 0; s < samples; s++) begin
         nf = $urandom_range(9) == 0 ? ni + $urandom_range(3) : ni;
         for (int f = 0; f < nf; f++) send(KIND_FEATURE, $urandom_range(2047), rand_value(),
                                           f == nf - 1);
      end
   endtask

   task automatic setup(int ni, int nh, int nl, int ha, int oa, int lk);
      drain();
      n_in = ni; n_hid = nh; n_lay = nl;
      write_csr(CSR_INPUT_COUNT, ni);
      write_csr(CSR_HIDDEN_COUNT, nh);
      write_csr(CSR_HIDDEN_LAYERS, nl);
      write_csr(CSR_HIDDEN_ACT, ha);
      write_csr(CSR_OUTPUT_ACT, oa);
      write_csr(CSR_LEAK, lk);
   endtask

   initial begin
      int sent;
      cycles = 0;
      sb.reset_state();
      send_idle_pct = 0; stall_pct = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: small net, all activations, extremes of values and leak
      setup(2, 2, 1, ACT_CLAMP, ACT_PASS, 4096);
      run_samples(2, 1);
      setup(1, 1, 2, ACT_LEAKY, ACT_LEAKY, 8191);
      run_samples(3, 1);
      setup(2, 1, 1, ACT_SIGMOID, ACT_CLAMP, 0);
      send(KIND_WEIGHT, 0, 32767, 1);
      send(KIND_WEIGHT, 1, -32768, 0);
      send(KIND_WEIGHT, 2047, 0, 0);
      for (int a = 2; a < 5; a++) send(KIND_WEIGHT, a, 32767, 0);
      send(KIND_FEATURE, 0, 32767, 0);
      send(KIND_FEATURE, 2047, -32768, 1);
      // random phases over idling mixes and configurations
      sent = 30;
      for (int ph = 0; sent < 1150; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 51; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 51; end
            default: begin send_idle_pct = 17; stall_pct = 17; end
         endcase
         if (ph == 1) setup(0, 0, 0, ACT_PASS, ACT_CLAMP, 2048);
         else if (ph == 2) setup(31, 2, 7, ACT_CLAMP, ACT_LEAKY, 100);
         else if (ph == 3) setup(16, 12, 4, ACT_LEAKY, ACT_SIGMOID, 41);
         else setup($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 3),
                    $urandom_range(3), $urandom_range(3), $urandom_range(8191));
         run_samples(8, ph % 2);
         sent += weight_words(sb.clampc(n_in, 16), sb.clampc(n_hid, 16),
                              sb.clampc(n_lay, 4)) + 8 * sb.clampc(n_in, 16);
      end
      stall_pct = 0;
      drain();
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
